@@ rtl/dam_pkg.sv @@
// Shared types and codes for the door alarm monitor.
// Holds the request, response, configuration and door state structs.
// No dependencies.
`timescale 1ns / 1ps

package dam_pkg;

   // Operation codes of a request.
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_OPENED = 3'd1;
   localparam logic [2:0] OP_CLOSED = 3'd2;
   localparam logic [2:0] OP_LOCK   = 3'd3;
   localparam logic [2:0] OP_EXIT   = 3'd4;

   // Door phases.
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_RELOCK     = 3'd1;
   localparam logic [2:0] PH_OPEN_LIMIT = 3'd2;
   localparam logic [2:0] PH_PRE_ALARM  = 3'd3;
   localparam logic [2:0] PH_TOO_LONG   = 3'd4;
   localparam logic [2:0] PH_FORCED     = 3'd5;

   // Alarm codes.
   localparam logic [1:0] ALM_NORMAL   = 2'd0;
   localparam logic [1:0] ALM_TOO_LONG = 2'd1;
   localparam logic [1:0] ALM_FORCED   = 2'd2;

   // Lock command values with a meaning of their own.
   localparam logic [2:0] VAL_LOCKED   = 3'd0;
   localparam logic [2:0] VAL_UNLOCKED = 3'd1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_FORCED_OPEN_EN = 3'd0;
   localparam logic [2:0] CSR_OPEN_LONG_EN   = 3'd1;
   localparam logic [2:0] CSR_LOCK_KIND      = 3'd2;
   localparam logic [2:0] CSR_SENSOR_EN      = 3'd3;
   localparam logic [2:0] CSR_OPEN_LIMIT     = 3'd4;
   localparam logic [2:0] CSR_ALARM_DELAY    = 3'd5;
   localparam logic [2:0] CSR_CLOSE_DELAY    = 3'd6;
   localparam logic [2:0] CSR_PULSE          = 3'd7;

   typedef struct packed {
      logic       forced_open_enable;
      logic       open_too_long_enable;
      logic       lock_kind;
      logic       sensor_enable;
      logic [7:0] open_limit_seconds;
      logic [7:0] alarm_delay_seconds;
      logic [7:0] close_delay_seconds;
      logic [7:0] pulse_seconds;
   } cfg_type;

   typedef struct packed {
      logic [2:0] operation;
      logic       door_sensor;
      logic [2:0] command_value;
   } req_type;

   typedef struct packed {
      logic       lock_drive;
      logic [2:0] door_state;
      logic [1:0] alarm_code;
      logic       alarm_changed;
      logic [2:0] lock_value;
      logic       timer_running;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  door_phase;
      logic [2:0]  held_value;
      logic [1:0]  alarm_now;
      logic        lock_out;
      logic [15:0] countdown;
      logic [15:0] pulse_left;
   } state_type;

endpackage

@@ rtl/dam_step.sv @@
// Next-state and response logic of the door alarm monitor for one request.
// Purely combinational; depends on dam_pkg.
`timescale 1ns / 1ps

module dam_step #(
   parameter int TICKS_PER_SECOND    = 100,
   parameter int AUTO_RELOCK_SECONDS = 3
) (
   input  dam_pkg::cfg_type   cfg,
   input  dam_pkg::req_type   req,
   input  dam_pkg::state_type cur,
   output dam_pkg::state_type nxt,
   output dam_pkg::rsp_type   rsp
);
   import dam_pkg::*;

   localparam logic [15:0] TPS_W        = 16'(TICKS_PER_SECOND);
   localparam logic [15:0] RELOCK_TICKS = 16'(AUTO_RELOCK_SECONDS * TICKS_PER_SECOND);
   localparam logic [15:0] HALF_TICKS   = 16'((5 * TICKS_PER_SECOND) / 10);
   localparam logic [7:0]  RELOCK_SECS  = 8'(AUTO_RELOCK_SECONDS);

   // Seconds to ticks, wrapped to the timer width.
   function automatic logic [15:0] to_ticks(input logic [7:0] secs);
      to_ticks = {8'd0, secs} * TPS_W;
   endfunction

   logic [2:0]  ph;
   logic [2:0]  hv;
   logic        lo;
   logic [15:0] cd;
   logic [15:0] pl;
   logic        fresh;
   logic        eval;
   logic        do_set;
   logic [2:0]  set_val;
   logic        door_open;
   logic [1:0]  alarm_next;

   assign door_open = cfg.sensor_enable & req.door_sensor;

   always_comb begin
      ph      = cur.door_phase;
      hv      = cur.held_value;
      lo      = cur.lock_out;
      cd      = cur.countdown;
      pl      = cur.pulse_left;
      fresh   = 1'b0;
      eval    = 1'b0;
      do_set  = 1'b0;
      set_val = VAL_LOCKED;

      // Decide whether the lock value is rewritten, and with what.
      unique case (req.operation)
         OP_TICK: begin
            // The unlock pulse runs out first; expiry is handled further down.
            if (hv == VAL_UNLOCKED) begin
               if (pl != 16'd0) begin
                  pl = pl - 16'd1;
               end
               if (pl == 16'd0) begin
                  do_set  = 1'b1;
                  set_val = VAL_LOCKED;
               end
            end
         end
         OP_LOCK: begin
            do_set  = 1'b1;
            set_val = req.command_value;
         end
         OP_EXIT: begin
            if (hv == VAL_LOCKED || hv == VAL_UNLOCKED) begin
               do_set  = 1'b1;
               set_val = VAL_UNLOCKED;
            end
         end
         default: begin
         end
      endcase

      // A new lock value: unlocking values energize the lock at once, a locked
      // value frees it if open with lock_kind 0 or shut with no timer armed.
      if (do_set) begin
         hv = set_val;
         if (hv[0]) begin
            if (hv == VAL_UNLOCKED) begin
               pl = (cfg.pulse_seconds != 8'd0) ? to_ticks(cfg.pulse_seconds) : HALF_TICKS;
            end
            lo   = 1'b1;
            ph   = PH_IDLE;
            cd   = 16'd0;
            eval = 1'b1;
         end else if (door_open) begin
            if (!cfg.lock_kind) begin
               lo = 1'b0;
            end
            if (cfg.open_too_long_enable) begin
               ph    = PH_OPEN_LIMIT;
               cd    = to_ticks(cfg.open_limit_seconds);
               fresh = 1'b1;
            end else begin
               ph = cfg.lock_kind ? PH_RELOCK : PH_IDLE;
               cd = 16'd0;
            end
         end else if (cd != 16'd0) begin
            ph = PH_RELOCK;
         end else begin
            lo = 1'b0;
            ph = PH_IDLE;
         end
      end

      if (req.operation == OP_OPENED) begin
         case (ph)
            PH_IDLE: begin
               if (!hv[0] && cfg.forced_open_enable) begin
                  if (cfg.alarm_delay_seconds != 8'd0) begin
                     cd = to_ticks(cfg.alarm_delay_seconds);
                  end else begin
                     ph   = PH_FORCED;
                     cd   = 16'd0;
                     eval = 1'b1;
                  end
               end else begin
                  cd = 16'd0;
               end
            end
            PH_RELOCK: begin
               if (cfg.open_too_long_enable) begin
                  ph = PH_OPEN_LIMIT;
                  cd = to_ticks(cfg.open_limit_seconds);
               end else begin
                  cd = 16'd0;
               end
            end
            PH_OPEN_LIMIT: cd = to_ticks(cfg.open_limit_seconds);
            PH_PRE_ALARM:  cd = to_ticks(cfg.alarm_delay_seconds);
            default:       cd = 16'd0;
         endcase
      end

      if (req.operation == OP_CLOSED) begin
         if (ph == PH_IDLE) begin
            cd = (hv[0] && cfg.lock_kind) ? RELOCK_TICKS : 16'd0;
         end else if (ph == PH_RELOCK) begin
            cd = RELOCK_TICKS;
         end else if (ph < PH_FORCED) begin
            if (cfg.close_delay_seconds != 8'd0) begin
               cd = to_ticks(cfg.close_delay_seconds);
            end else begin
               if (cfg.lock_kind) begin
                  ph = PH_RELOCK;
                  cd = RELOCK_TICKS;
               end else begin
                  ph = PH_IDLE;
                  cd = 16'd0;
               end
               eval = 1'b1;
            end
         end
      end

      // Countdown; a timer armed during this tick does not count yet.
      // Expiry acts on the phase held at the start of the tick.
      if (req.operation == OP_TICK && cd != 16'd0 && !fresh) begin
         cd = cd - 16'd1;
         if (cd == 16'd0) begin
            if (cur.door_phase == PH_IDLE) begin
               if (door_open) begin
                  ph   = PH_FORCED;
                  eval = 1'b1;
               end
            end else if (cur.door_phase == PH_RELOCK) begin
               lo = 1'b0;
               ph = PH_IDLE;
            end else if (cur.door_phase < PH_FORCED && !door_open) begin
               if (cfg.lock_kind && cfg.close_delay_seconds < RELOCK_SECS) begin
                  ph = PH_RELOCK;
                  cd = to_ticks(RELOCK_SECS - cfg.close_delay_seconds);
               end else begin
                  if (cfg.lock_kind) begin
                     lo = 1'b0;
                  end
                  ph = PH_IDLE;
               end
               eval = 1'b1;
            end else if (cur.door_phase == PH_OPEN_LIMIT &&
                         cfg.alarm_delay_seconds != 8'd0) begin
               ph = PH_PRE_ALARM;
               cd = to_ticks(cfg.alarm_delay_seconds);
            end else if (cur.door_phase == PH_OPEN_LIMIT ||
                         cur.door_phase == PH_PRE_ALARM) begin
               ph   = PH_TOO_LONG;
               eval = 1'b1;
            end
         end
      end

      // The alarm is re-evaluated at most once per request, after the last
      // phase change, so the final phase decides it.
      alarm_next = cur.alarm_now;
      if (eval) begin
         if (ph == PH_TOO_LONG) begin
            alarm_next = ALM_TOO_LONG;
         end else if (ph == PH_FORCED) begin
            alarm_next = ALM_FORCED;
         end else begin
            alarm_next = ALM_NORMAL;
         end
      end
   end

   assign nxt.door_phase = ph;
   assign nxt.held_value = hv;
   assign nxt.alarm_now  = alarm_next;
   assign nxt.lock_out   = lo;
   assign nxt.countdown  = cd;
   assign nxt.pulse_left = pl;

   assign rsp.lock_drive    = lo;
   assign rsp.door_state    = ph;
   assign rsp.alarm_code    = alarm_next;
   assign rsp.alarm_changed = (alarm_next != cur.alarm_now);
   assign rsp.lock_value    = hv;
   assign rsp.timer_running = (cd != 16'd0);

endmodule

@@ rtl/door_alarm_monitor_unit.sv @@
// Top level of the door alarm monitor: request and response channels,
// configuration registers and door state. Depends on dam_pkg and dam_step.
`timescale 1ns / 1ps

// The door alarm monitor controls one access door. Each request is an event
// (a time tick, door opened, door closed, a lock command or an exit request)
// that carries the polarity-corrected door sensor, and each request produces
// exactly one response with the lock drive, door phase, alarm code, an
// alarm-changed flag, the lock value held and whether the countdown timer is
// armed. Requests are taken into an input register; the next-state logic then
// updates the door state and fills the response register when that register is
// free, so a request passes through the input register and then the response
// register. A new request can be accepted in every cycle while req_stall is
// low, and throughput is one request per clock while rsp_stall stays low; the
// state update between the two registers is combinational. The response
// register and the input register are separate, so while a response waits on
// rsp_stall one more request is still taken into the empty input register;
// after that req_stall follows rsp_stall until the response is taken. Timers
// count in ticks; a setting of S seconds loads S * TICKS_PER_SECOND ticks,
// wrapped to 16 bits. Configuration registers are written through the csr_
// port and should only change while no request is in flight.

module door_alarm_monitor_unit #(
   parameter int TICKS_PER_SECOND    = 100,
   parameter int AUTO_RELOCK_SECONDS = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dam_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dam_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import dam_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in;
   logic      in_vld_ff, in_vld_in;
   req_type   in_data_ff;
   logic      rsp_vld_ff, rsp_vld_in;
   rsp_type   rsp_data_ff;
   rsp_type   step_rsp;

   logic rsp_free;
   logic advance;
   logic req_accept;

   // The response register frees up when it is empty or being taken.
   assign rsp_free   = !rsp_vld_ff || !rsp_stall;
   // The buffered request moves into the state update when there is room.
   assign advance    = in_vld_ff && rsp_free;
   assign req_stall  = in_vld_ff && !rsp_free;
   assign req_accept = req_valid && !req_stall;

   assign in_vld_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign rsp_vld_in = advance ? 1'b1 : (rsp_stall ? rsp_vld_ff : 1'b0);

   dam_step #(
      .TICKS_PER_SECOND    (TICKS_PER_SECOND),
      .AUTO_RELOCK_SECONDS (AUTO_RELOCK_SECONDS)
   ) u_step (
      .cfg (cfg_ff),
      .req (in_data_ff),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   // Configuration register decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FORCED_OPEN_EN: cfg_in.forced_open_enable   = csr_wdata[0];
            CSR_OPEN_LONG_EN:   cfg_in.open_too_long_enable = csr_wdata[0];
            CSR_LOCK_KIND:      cfg_in.lock_kind            = csr_wdata[0];
            CSR_SENSOR_EN:      cfg_in.sensor_enable        = csr_wdata[0];
            CSR_OPEN_LIMIT:     cfg_in.open_limit_seconds   = csr_wdata;
            CSR_ALARM_DELAY:    cfg_in.alarm_delay_seconds  = csr_wdata;
            CSR_CLOSE_DELAY:    cfg_in.close_delay_seconds  = csr_wdata;
            CSR_PULSE:          cfg_in.pulse_seconds        = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '0;
         state_ff   <= '0;
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
